@@ rtl/core/fspfl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fspfl_pkg;

  // default pool geometry
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int MAX_EPB_DEF    = 64;

  // link store and field widths
  localparam int HANDLE_W   = 10;
  localparam int LINK_DEPTH = 1024;
  localparam int EPB_W      = 7;
  localparam int COUNT_W    = 11;
  localparam int EPB_CAP    = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  // handle decode by reciprocal multiply: exact for 10-bit handles
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;

  // request commands
  localparam logic [1:0] CMD_ALLOC     = 2'd0;
  localparam logic [1:0] CMD_FREE      = 2'd1;
  localparam logic [1:0] CMD_ADD_BLOCK = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED   = 2'd1;
  localparam logic [1:0] ST_BLOCK_LIMIT = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE  = 2'd3;

  // configuration register indexes
  localparam logic CFG_IDX_EPB  = 1'b0;
  localparam logic CFG_IDX_GROW = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CARVE,
    S_ALLOC_RD,
    S_ALLOC_POP,
    S_FREE_CHK
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/fspfl_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fspfl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/fixed_size_pool_free_list_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  signals                                        handshake
// request   in         in_command[1:0] in_handle[9:0]                 start & !busy
// result    out        out_slot[9:0] out_status[1:0] out_all_free     out_strobe, one cycle
// config    in         cfg_index cfg_wdata[6:0]                       cfg_we
//
// allocate and free each do a link store read (allocate) or a handle decode
// (free), then the list update. add_block carves entries_per_block entries; an
// allocate that must carve first then pops the new head. Allocate and add_block
// failures and code 3 answer from idle. The link store write port, one entry
// a cycle, sets the carving time. Reset is synchronous and clears control state
// only. Results cannot be stalled; busy alone holds off new requests.

module fixed_size_pool_free_list_core
  import fspfl_pkg::*;
#(
  parameter int MAX_BLOCKS            = MAX_BLOCKS_DEF,
  parameter int MAX_ENTRIES_PER_BLOCK = MAX_EPB_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_command,
  input  wire logic [HANDLE_W-1:0] in_handle,
  output logic                     out_strobe,
  output logic      [HANDLE_W-1:0] out_slot,
  output logic      [1:0]          out_status,
  output logic                     out_all_free,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [EPB_W-1:0]    cfg_wdata
);

  localparam int BCW    = $clog2(MAX_BLOCKS + 1);
  localparam int MW     = 11;
  localparam int CAPW   = (EPB_W + BCW > COUNT_W) ? EPB_W + BCW : COUNT_W;
  localparam int EPB_LIM_I = (MAX_ENTRIES_PER_BLOCK < EPB_CAP) ? MAX_ENTRIES_PER_BLOCK
                                                               : EPB_CAP;
  localparam logic [EPB_W-1:0]   EPB_LIM = EPB_W'(EPB_LIM_I);
  localparam logic [MW-1:0]      M_W     = MW'(MAX_ENTRIES_PER_BLOCK);
  localparam logic [BCW-1:0]     BLK_MAX = BCW'(MAX_BLOCKS);
  localparam logic [RECIP_W-1:0] RECIP   =
    RECIP_W'(((1 << RECIP_SHIFT) + MAX_ENTRIES_PER_BLOCK - 1) / MAX_ENTRIES_PER_BLOCK);

  state_t state_r, state_nxt;

  logic [HANDLE_W-1:0] head_r, head_nxt;
  logic                head_valid_r, head_valid_nxt;
  logic [BCW-1:0]      block_count_r, block_count_nxt;
  logic [COUNT_W-1:0]  free_count_r, free_count_nxt;
  logic [HANDLE_W-1:0] base_r, base_nxt;
  logic [5:0]          idx_r, idx_nxt;
  logic                alloc_pend_r, alloc_pend_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [HANDLE_W-1:0] blk_r, blk_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  logic [HANDLE_W-1:0] out_slot_r, out_slot_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [EPB_W-1:0]    cfg_epb_r;
  logic                cfg_grow_r;

  logic                ram_we;
  logic [HANDLE_W-1:0] ram_waddr;
  logic [HANDLE_W-1:0] ram_wdata;
  logic [HANDLE_W-1:0] ram_rdata;

  logic [EPB_W-1:0]     epb;
  logic                 accept;
  logic                 at_limit;
  logic [HANDLE_W-1:0]  tail_link;
  logic [BCW+MW-1:0]    base_prod;
  logic [30:0]          recip_prod;
  logic [HANDLE_W+MW-1:0] blk_lo;
  logic                 handle_ok;
  logic                 carve_last;
  logic [COUNT_W:0]     count_sum;
  logic [COUNT_W-1:0]   count_added;
  logic [CAPW-1:0]      capacity;

  // next_link store
  fspfl_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // effective entries per block, saturated to 1..limit
  always_comb begin
    epb = (cfg_epb_r == '0) ? EPB_W'(1) : cfg_epb_r;
    if (epb > EPB_LIM) begin
      epb = EPB_LIM;
    end
  end

  assign accept    = start && !busy;
  assign at_limit  = (block_count_r >= BLK_MAX);
  assign tail_link = head_valid_r ? head_r : '0;

  // base slot of the next block, handles wrap at the link store depth
  assign base_prod = (BCW+MW)'(block_count_r) * (BCW+MW)'(M_W);

  // handle decode: block number by reciprocal, then entry range check
  assign recip_prod = 31'(in_handle) * 31'(RECIP);
  assign blk_lo     = (HANDLE_W+MW)'(blk_r) * (HANDLE_W+MW)'(M_W);
  assign handle_ok  = ((MW)'(blk_r) < (MW)'(block_count_r)) &&
                      ((HANDLE_W+MW+1)'(handle_r) <
                       (HANDLE_W+MW+1)'(blk_lo) + (HANDLE_W+MW+1)'(epb));

  assign carve_last = ((EPB_W)'(idx_r) + EPB_W'(1)) == epb;

  // saturating count add, used for carving and for free
  always_comb begin
    if (state_r == S_CARVE) begin
      count_sum = (COUNT_W+1)'(free_count_r) + (COUNT_W+1)'(epb);
    end else begin
      count_sum = (COUNT_W+1)'(free_count_r) + (COUNT_W+1)'(1);
    end
    count_added = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    head_valid_nxt  = head_valid_r;
    block_count_nxt = block_count_r;
    free_count_nxt  = free_count_r;
    base_nxt        = base_r;
    idx_nxt         = idx_r;
    alloc_pend_nxt  = alloc_pend_r;
    handle_nxt      = handle_r;
    blk_nxt         = blk_r;
    out_strobe_nxt  = 1'b0;
    out_slot_nxt    = '0;
    out_status_nxt  = ST_OK;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          handle_nxt = in_handle;
          blk_nxt    = recip_prod[RECIP_SHIFT +: HANDLE_W];
          base_nxt   = base_prod[HANDLE_W-1:0];
          idx_nxt    = '0;
          priority if (in_command == CMD_ALLOC) begin
            if (free_count_r != '0) begin
              state_nxt = S_ALLOC_POP;
            end else if (!cfg_grow_r && block_count_r != '0) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_EXHAUSTED;
            end else if (at_limit) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_BLOCK_LIMIT;
            end else begin
              alloc_pend_nxt = 1'b1;
              state_nxt      = S_CARVE;
            end
          end else if (in_command == CMD_FREE) begin
            state_nxt = S_FREE_CHK;
          end else if (in_command == CMD_ADD_BLOCK) begin
            if (at_limit) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_BLOCK_LIMIT;
            end else begin
              alloc_pend_nxt = 1'b0;
              state_nxt      = S_CARVE;
            end
          end else begin
            out_strobe_nxt = 1'b1;
          end
        end
      end

      // chain one entry a cycle, the last one onto the old head
      S_CARVE: begin
        ram_we    = 1'b1;
        ram_waddr = base_r + HANDLE_W'(idx_r);
        if (carve_last) begin
          ram_wdata       = tail_link;
          head_nxt        = base_r;
          head_valid_nxt  = 1'b1;
          block_count_nxt = block_count_r + BCW'(1);
          free_count_nxt  = count_added;
          if (alloc_pend_r) begin
            state_nxt = S_ALLOC_RD;
          end else begin
            state_nxt      = S_IDLE;
            out_strobe_nxt = 1'b1;
          end
        end else begin
          ram_wdata = base_r + HANDLE_W'(idx_r) + HANDLE_W'(1);
          idx_nxt   = idx_r + 6'd1;
        end
      end

      // link of the new head is being read
      S_ALLOC_RD: begin
        state_nxt = S_ALLOC_POP;
      end

      // pop the head
      S_ALLOC_POP: begin
        state_nxt      = S_IDLE;
        out_strobe_nxt = 1'b1;
        out_slot_nxt   = head_r;
        free_count_nxt = free_count_r - COUNT_W'(1);
        if (free_count_r == COUNT_W'(1)) begin
          head_valid_nxt = 1'b0;
        end else begin
          head_nxt = ram_rdata;
        end
      end

      // push the handle if it lies in a carved block
      S_FREE_CHK: begin
        state_nxt      = S_IDLE;
        out_strobe_nxt = 1'b1;
        if (handle_ok) begin
          ram_we         = 1'b1;
          ram_waddr      = handle_r;
          ram_wdata      = tail_link;
          head_nxt       = handle_r;
          head_valid_nxt = 1'b1;
          free_count_nxt = count_added;
        end else begin
          out_status_nxt = ST_BAD_HANDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '0;
      head_valid_r  <= 1'b0;
      block_count_r <= '0;
      free_count_r  <= '0;
      idx_r         <= '0;
      alloc_pend_r  <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      head_valid_r  <= head_valid_nxt;
      block_count_r <= block_count_nxt;
      free_count_r  <= free_count_nxt;
      idx_r         <= idx_nxt;
      alloc_pend_r  <= alloc_pend_nxt;
      out_strobe_r  <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    handle_r     <= handle_nxt;
    blk_r        <= blk_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_epb_r  <= EPB_W'(1);
      cfg_grow_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_EPB:  cfg_epb_r  <= cfg_wdata;
        CFG_IDX_GROW: cfg_grow_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // all slots free: count against carved capacity, state is settled during the strobe
  assign capacity = CAPW'(epb) * CAPW'(block_count_r);

  assign busy         = (state_r != S_IDLE);
  assign out_strobe   = out_strobe_r;
  assign out_slot     = out_slot_r;
  assign out_status   = out_status_r;
  assign out_all_free = (CAPW'(free_count_r) == capacity);

endmodule

`default_nettype wire
